@@ rtl/core/uvs_pkg.sv @@
package uvs_pkg;

  // largest ring count the datapath supports
  localparam int unsigned MAX_SEGMENTS = 255;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;

  // fraction bits of the long division; taps for texture and latitude
  localparam int unsigned DIV_LAST = 32;
  localparam int unsigned TEX_TAP  = 16;
  localparam int unsigned TH_TAP   = 31;

  // cordic start vector, gain-corrected, scale 2^30
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [7:0] SEG_RESET = 8'd48;

  // arctangent table, full turn = 2^32
  localparam logic signed [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               in_range;
    logic               quad_valid;
    logic [15:0]        first_corner;
    logic [15:0]        second_corner;
    logic [15:0]        third_corner;
    logic [15:0]        fourth_corner;
    logic [18:0]        index_slot;
  } out_t;

  // classification and index results carried alongside the maths
  typedef struct packed {
    logic        in_range;
    logic        quad_valid;
    logic [7:0]  seg;
    logic [15:0] first_corner;
    logic [15:0] second_corner;
    logic [15:0] third_corner;
    logic [15:0] fourth_corner;
    logic [18:0] index_slot;
  } side_t;

  // queued item between front and back
  typedef struct packed {
    side_t      side;
    logic [7:0] row;
    logic [7:0] col;
  } item_t;

  // one stage of the two-lane long division
  typedef struct packed {
    logic        vld;
    side_t       side;
    logic [7:0]  rem_r;
    logic [7:0]  rem_c;
    logic [32:0] q_r;
    logic [32:0] q_c;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] th;
  } dstage_t;

  // round-half-up carry of a quotient given its remainder
  function automatic logic rnd_carry(logic [7:0] rem, logic [7:0] seg);
    logic [8:0] sum;
    sum = {1'b0, rem} + {2'b0, seg[7:1]};
    return sum >= {1'b0, seg};
  endfunction

endpackage

@@ rtl/core/uvs_front.sv @@
module uvs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uvs_pkg::in_t   in_data_i,
  input  logic [7:0]     seg_i,
  input  logic           pop_i,
  output logic           item_valid_o,
  output uvs_pkg::item_t item_o
);

  uvs_pkg::item_t fifo_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push;
  uvs_pkg::item_t cls;
  logic [7:0]     seg;
  logic [8:0]     w;
  logic [16:0]    rw;
  logic [16:0]    base;
  logic [16:0]    lin;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_q];

  // clamp segments and classify the point
  always_comb begin
    seg = seg_i;
    if (seg == 8'd0) begin
      seg = 8'd1;
    end
    if (32'(seg) > uvs_pkg::MAX_SEGMENTS) begin
      seg = 8'(uvs_pkg::MAX_SEGMENTS);
    end
    w    = {1'b0, seg} + 9'd1;
    rw   = {9'd0, in_data_i.row} * {8'd0, w};
    base = rw + {9'd0, in_data_i.col};
    lin  = base - {9'd0, in_data_i.row};
    cls  = '0;
    cls.side.seg = seg;
    if (in_data_i.row <= seg && in_data_i.col <= seg) begin
      cls.side.in_range = 1'b1;
      cls.row           = in_data_i.row;
      cls.col           = in_data_i.col;
      if (in_data_i.row < seg && in_data_i.col < seg) begin
        cls.side.quad_valid    = 1'b1;
        cls.side.first_corner  = base[15:0];
        cls.side.second_corner = base[15:0] + 16'd1;
        cls.side.third_corner  = base[15:0] + {7'd0, w} + 16'd1;
        cls.side.fourth_corner = base[15:0] + {7'd0, w};
        cls.side.index_slot    = {2'd0, lin} * 19'd6;
      end
    end
  end

  // two-entry item queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cls;
    end
  end

endmodule

@@ rtl/core/uvs_div.sv @@
module uvs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             item_valid_i,
  input  uvs_pkg::item_t   item_i,
  output uvs_pkg::dstage_t res_o
);

  uvs_pkg::dstage_t st_q [uvs_pkg::DIV_LAST + 1];
  uvs_pkg::dstage_t st0;
  logic             br, bc;

  // one fraction bit per stage for both lanes, taps captured on the way
  function automatic uvs_pkg::dstage_t div_step(uvs_pkg::dstage_t p, int unsigned k);
    uvs_pkg::dstage_t n;
    logic [8:0]       tr, tc, s9;
    logic             b_r, b_c;
    n   = p;
    s9  = {1'b0, p.side.seg};
    tr  = {p.rem_r, 1'b0};
    tc  = {p.rem_c, 1'b0};
    b_r = tr >= s9;
    b_c = tc >= s9;
    n.rem_r = b_r ? 8'(tr - s9) : tr[7:0];
    n.rem_c = b_c ? 8'(tc - s9) : tc[7:0];
    n.q_r   = {p.q_r[31:0], b_r};
    n.q_c   = {p.q_c[31:0], b_c};
    if (k == uvs_pkg::TEX_TAP + 1) begin
      n.tex_u = p.q_c[16:0] + 17'(uvs_pkg::rnd_carry(p.rem_c, p.side.seg));
      n.tex_v = p.q_r[16:0] + 17'(uvs_pkg::rnd_carry(p.rem_r, p.side.seg));
    end
    if (k == uvs_pkg::TH_TAP + 1) begin
      n.th = p.q_r[31:0] + 32'(uvs_pkg::rnd_carry(p.rem_r, p.side.seg));
    end
    return n;
  endfunction

  // integer bit of n/seg
  always_comb begin
    st0       = '0;
    st0.vld   = item_valid_i;
    st0.side  = item_i.side;
    br        = item_i.row >= item_i.side.seg;
    bc        = item_i.col >= item_i.side.seg;
    st0.rem_r = br ? item_i.row - item_i.side.seg : item_i.row;
    st0.rem_c = bc ? item_i.col - item_i.side.seg : item_i.col;
    st0.q_r   = {32'd0, br};
    st0.q_c   = {32'd0, bc};
  end

  // division pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k <= uvs_pkg::DIV_LAST; k++) begin
        st_q[k] <= '0;
      end
    end else if (en_i) begin
      st_q[0] <= st0;
      for (int unsigned k = 1; k <= uvs_pkg::DIV_LAST; k++) begin
        st_q[k] <= div_step(st_q[k-1], k);
      end
    end
  end

  assign res_o = st_q[uvs_pkg::DIV_LAST];

endmodule

@@ rtl/core/uvs_cordic.sv @@
module uvs_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  uvs_pkg::dstage_t d_i,
  output logic             res_valid_o,
  output uvs_pkg::out_t    res_o
);

  typedef struct packed {
    logic                vld;
    uvs_pkg::side_t      side;
    logic [16:0]         tex_u;
    logic [16:0]         tex_v;
    logic signed [31:0]  x_t, y_t, z_t;
    logic signed [31:0]  x_p, y_p, z_p;
    logic [1:0]          quad_t, quad_p;
  } cstage_t;

  typedef struct packed {
    logic               vld;
    uvs_pkg::side_t     side;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [31:0] ct, st, cp, sp;
  } mstage_t;

  typedef struct packed {
    logic               vld;
    uvs_pkg::side_t     side;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [31:0] ct;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_z;
  } pstage_t;

  cstage_t     cs_q [uvs_pkg::CORDIC_STEPS + 1];
  cstage_t     cs0;
  mstage_t     m_q, m_d;
  pstage_t     p_q;
  logic [32:0] ph_full;
  logic [31:0] ph;
  cstage_t     last;

  // one rotation of both lanes
  function automatic cstage_t rot(cstage_t p, int unsigned i);
    cstage_t n;
    n = p;
    if (!p.z_t[31]) begin
      n.x_t = p.x_t - (p.y_t >>> i);
      n.y_t = p.y_t + (p.x_t >>> i);
      n.z_t = p.z_t - uvs_pkg::ATAN_TURNS[i];
    end else begin
      n.x_t = p.x_t + (p.y_t >>> i);
      n.y_t = p.y_t - (p.x_t >>> i);
      n.z_t = p.z_t + uvs_pkg::ATAN_TURNS[i];
    end
    if (!p.z_p[31]) begin
      n.x_p = p.x_p - (p.y_p >>> i);
      n.y_p = p.y_p + (p.x_p >>> i);
      n.z_p = p.z_p - uvs_pkg::ATAN_TURNS[i];
    end else begin
      n.x_p = p.x_p + (p.y_p >>> i);
      n.y_p = p.y_p - (p.x_p >>> i);
      n.z_p = p.z_p + uvs_pkg::ATAN_TURNS[i];
    end
    return n;
  endfunction

  // round scale 2^60 to 2^14, saturating
  function automatic logic signed [15:0] rnd46(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd35184372088832) >>> 46;
    if (r > 64'sd16384) begin
      return 16'sd16384;
    end
    if (r < -64'sd16384) begin
      return -16'sd16384;
    end
    return r[15:0];
  endfunction

  // round scale 2^30 to 2^14, saturating
  function automatic logic signed [15:0] rnd16(logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd32768) >>> 16;
    if (r > 33'sd16384) begin
      return 16'sd16384;
    end
    if (r < -33'sd16384) begin
      return -16'sd16384;
    end
    return r[15:0];
  endfunction

  // longitude phase rounding and cordic start vectors
  always_comb begin
    ph_full    = d_i.q_c + 33'(uvs_pkg::rnd_carry(d_i.rem_c, d_i.side.seg));
    ph         = ph_full[31:0];
    cs0        = '0;
    cs0.vld    = d_i.vld;
    cs0.side   = d_i.side;
    cs0.tex_u  = d_i.tex_u;
    cs0.tex_v  = d_i.tex_v;
    cs0.x_t    = uvs_pkg::GAIN_Q30;
    cs0.x_p    = uvs_pkg::GAIN_Q30;
    cs0.z_t    = {2'b00, d_i.th[29:0]};
    cs0.z_p    = {2'b00, ph[29:0]};
    cs0.quad_t = d_i.th[31:30];
    cs0.quad_p = ph[31:30];
  end

  // quadrant fold, sin(theta) made positive
  always_comb begin
    last      = cs_q[uvs_pkg::CORDIC_STEPS];
    m_d       = '0;
    m_d.vld   = last.vld;
    m_d.side  = last.side;
    m_d.tex_u = last.tex_u;
    m_d.tex_v = last.tex_v;
    case (last.quad_t)
      2'd0: begin m_d.ct = last.x_t;  m_d.st = last.y_t;  end
      2'd1: begin m_d.ct = -last.y_t; m_d.st = last.x_t;  end
      2'd2: begin m_d.ct = -last.x_t; m_d.st = -last.y_t; end
      default: begin m_d.ct = last.y_t; m_d.st = -last.x_t; end
    endcase
    case (last.quad_p)
      2'd0: begin m_d.cp = last.x_p;  m_d.sp = last.y_p;  end
      2'd1: begin m_d.cp = -last.y_p; m_d.sp = last.x_p;  end
      2'd2: begin m_d.cp = -last.x_p; m_d.sp = -last.y_p; end
      default: begin m_d.cp = last.y_p; m_d.sp = -last.x_p; end
    endcase
    if (m_d.st[31]) begin
      m_d.st = -m_d.st;
    end
  end

  // rotation stages, fold and product registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i <= uvs_pkg::CORDIC_STEPS; i++) begin
        cs_q[i] <= '0;
      end
      m_q <= '0;
      p_q <= '0;
    end else if (en_i) begin
      cs_q[0] <= cs0;
      for (int unsigned i = 1; i <= uvs_pkg::CORDIC_STEPS; i++) begin
        cs_q[i] <= rot(cs_q[i-1], i - 1);
      end
      m_q        <= m_d;
      p_q.vld    <= m_q.vld;
      p_q.side   <= m_q.side;
      p_q.tex_u  <= m_q.tex_u;
      p_q.tex_v  <= m_q.tex_v;
      p_q.ct     <= m_q.ct;
      p_q.prod_x <= 64'(m_q.cp) * 64'(m_q.st);
      p_q.prod_z <= 64'(m_q.sp) * 64'(m_q.st);
    end
  end

  // final rounding and masking of out-of-range points
  always_comb begin
    res_valid_o          = p_q.vld;
    res_o                = '0;
    res_o.in_range       = p_q.side.in_range;
    res_o.quad_valid     = p_q.side.quad_valid;
    res_o.first_corner   = p_q.side.first_corner;
    res_o.second_corner  = p_q.side.second_corner;
    res_o.third_corner   = p_q.side.third_corner;
    res_o.fourth_corner  = p_q.side.fourth_corner;
    res_o.index_slot     = p_q.side.index_slot;
    if (p_q.side.in_range) begin
      res_o.pos_x = rnd46(-p_q.prod_x);
      res_o.pos_y = rnd16(-{p_q.ct[31], p_q.ct});
      res_o.pos_z = rnd46(p_q.prod_z);
      res_o.tex_u = p_q.tex_u;
      res_o.tex_v = p_q.tex_v;
    end
  end

endmodule

@@ rtl/core/uv_sphere_vertex_generator.sv @@
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i (row, col)
// out     | output    | out_valid_o / out_ready_i | out_data_o (position, tex, quad)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (segments)
//
// one item per clock while not stalled; an item passes the queue, the 33-stage long
// division, the 16-stage cordic, fold, product and output registers to out_valid_o.
// reset sets segments to 48 and empties the queue and all pipeline stages.
// a held result stalls the whole back pipeline; the two-entry queue keeps taking
// items until it is full. cfg_ready_o is always high.
module uv_sphere_vertex_generator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uvs_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output uvs_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);

  logic             en;
  logic             item_valid;
  logic             pop;
  uvs_pkg::item_t   item;
  uvs_pkg::dstage_t dres;
  logic             res_valid;
  uvs_pkg::out_t    res;
  logic [7:0]       seg_q;
  logic             out_valid_q;
  uvs_pkg::out_t    out_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || out_ready_i;
  assign pop         = en && item_valid;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // segments register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= uvs_pkg::SEG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seg_q <= cfg_data_i;
    end
  end

  uvs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .seg_i        (seg_q),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  uvs_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .item_valid_i (pop),
    .item_i       (item),
    .res_o        (dres)
  );

  uvs_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .d_i         (dres),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      out_data_o.pos_x == 16'sd0 && out_data_o.pos_y == 16'sd0 &&
      out_data_o.pos_z == 16'sd0 && out_data_o.tex_u == 17'd0 &&
      out_data_o.tex_v == 17'd0 && !out_data_o.quad_valid)
    else $error("out-of-range item carries nonzero fields");

  a_quad_corners: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.quad_valid |->
      out_data_o.in_range &&
      out_data_o.second_corner == out_data_o.first_corner + 16'd1 &&
      out_data_o.third_corner == out_data_o.fourth_corner + 16'd1)
    else $error("quad corners inconsistent");

  a_tex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tex_u <= 17'd65536 && out_data_o.tex_v <= 17'd65536)
    else $error("texture coordinate beyond one");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pos_y <= 16'sd16384 && out_data_o.pos_y >= -16'sd16384 &&
      out_data_o.pos_x <= 16'sd16384 && out_data_o.pos_x >= -16'sd16384)
    else $error("position outside unit range");
`endif

endmodule

@@ tb/sv/tb_uv_sphere_vertex_generator.sv @@
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;

  localparam int unsigned LATENCY = 53;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  uvs_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  uvs_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  // segment count as the block sees it
  logic [7:0] seg_now;
  uvs_pkg::out_t vertex_q[$];
  int unsigned mismatches = 0;
  int unsigned points_sent = 0;
  int unsigned points_checked = 0;
  bit idle_gaps = 1'b1;

  // cordic arctangent table, full turn = 2^32
  longint atan_tab [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  uv_sphere_vertex_generator uut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor division by 2^n
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_unit(longint v, int n);
    longint r;
    r = fshr(v + (longint'(1) <<< (n - 1)), n);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // cos and sin of a 32-bit phase at scale 2^30
  task automatic phase_sincos(input longint phase, output longint c, output longint s);
    longint x, y, z, dx, dy;
    int q;
    x = 652032874;
    y = 0;
    z = phase & 64'h3FFFFFFF;
    q = int'((phase >> 30) & 3);
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // expected vertex for one grid point
  task automatic vertex_of(input uvs_pkg::in_t p, output uvs_pkg::out_t v);
    longint seg, r, c, thp, php, ct, st, cp, sp, w;
    v = '0;
    seg = (seg_now == 0) ? 1 : seg_now;
    r = p.row;
    c = p.col;
    if (r > seg || c > seg) return;
    thp = ((r <<< 31) + seg / 2) / seg;
    php = (((c <<< 32) + seg / 2) / seg) & 64'hFFFFFFFF;
    phase_sincos(thp, ct, st);
    phase_sincos(php, cp, sp);
    if (st < 0) st = -st;
    v.pos_x = 16'(round_unit(-(cp * st), 46));
    v.pos_y = 16'(round_unit(-ct, 16));
    v.pos_z = 16'(round_unit(sp * st, 46));
    v.tex_u = 17'(((c <<< 16) + seg / 2) / seg);
    v.tex_v = 17'(((r <<< 16) + seg / 2) / seg);
    v.in_range = 1'b1;
    if (r < seg && c < seg) begin
      w = seg + 1;
      v.quad_valid = 1'b1;
      v.first_corner = 16'(r * w + c);
      v.second_corner = 16'(r * w + c + 1);
      v.third_corner = 16'((r + 1) * w + c + 1);
      v.fourth_corner = 16'((r + 1) * w + c);
      v.index_slot = 19'(6 * (r * seg + c));
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    uvs_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vertex_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = vertex_q.pop_front();
        points_checked++;
        if (out_data_o.pos_x !== e.pos_x) report("pos_x", out_data_o.pos_x, e.pos_x);
        if (out_data_o.pos_y !== e.pos_y) report("pos_y", out_data_o.pos_y, e.pos_y);
        if (out_data_o.pos_z !== e.pos_z) report("pos_z", out_data_o.pos_z, e.pos_z);
        if (out_data_o.tex_u !== e.tex_u) report("tex_u", out_data_o.tex_u, e.tex_u);
        if (out_data_o.tex_v !== e.tex_v) report("tex_v", out_data_o.tex_v, e.tex_v);
        if (out_data_o.in_range !== e.in_range)
          report("in_range", out_data_o.in_range, e.in_range);
        if (out_data_o.quad_valid !== e.quad_valid)
          report("quad_valid", out_data_o.quad_valid, e.quad_valid);
        if (out_data_o.first_corner !== e.first_corner)
          report("first_corner", out_data_o.first_corner, e.first_corner);
        if (out_data_o.second_corner !== e.second_corner)
          report("second_corner", out_data_o.second_corner, e.second_corner);
        if (out_data_o.third_corner !== e.third_corner)
          report("third_corner", out_data_o.third_corner, e.third_corner);
        if (out_data_o.fourth_corner !== e.fourth_corner)
          report("fourth_corner", out_data_o.fourth_corner, e.fourth_corner);
        if (out_data_o.index_slot !== e.index_slot)
          report("index_slot", out_data_o.index_slot, e.index_slot);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (!idle_gaps) out_ready_i <= 1'b1;
    else if (out_valid_o && out_ready_i && $urandom_range(0, 7) == 0) out_ready_i <= 1'b0;
    else if (!out_ready_i) out_ready_i <= ($urandom_range(0, 2) == 0);
    else out_ready_i <= 1'b1;
  end

  // send one grid point, with an optional gap first
  task automatic send_point(input logic [7:0] r, input logic [7:0] c);
    uvs_pkg::in_t p;
    uvs_pkg::out_t v;
    if (idle_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    p.row = r;
    p.col = c;
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    vertex_of(p, v);
    vertex_q.push_back(v);
    points_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // write segment count while idle
  task automatic set_segments(input logic [7:0] s);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seg_now = s;
  endtask

  task automatic test_reset_value();
    send_point(8'd0, 8'd0);
    send_point(8'd24, 8'd12);
    send_point(8'd48, 8'd48);
    send_point(8'd49, 8'd0);
    wait_drained();
  endtask

  // poles, equator, last row and column, out of range
  task automatic test_corners();
    set_segments(8'd255);
    send_point(8'd0, 8'd0);
    send_point(8'd255, 8'd255);
    send_point(8'd254, 8'd254);
    send_point(8'd128, 8'd64);
    send_point(8'd255, 8'd0);
    send_point(8'd0, 8'd255);
    wait_drained();
    set_segments(8'd1);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd1);
    send_point(8'd2, 8'd0);
    send_point(8'd0, 8'd170);
    wait_drained();
    // zero is taken as one
    set_segments(8'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd0);
    send_point(8'd1, 8'd2);
    send_point(8'd255, 8'd85);
    wait_drained();
  endtask

  task automatic test_random_points();
    logic [7:0] segs [6] = '{8'd4, 8'd7, 8'd48, 8'd100, 8'd200, 8'd255};
    logic [7:0] s, r, c;
    for (int ph = 0; ph < 8; ph++) begin
      s = (ph < 6) ? segs[ph] : 8'($urandom_range(1, 255));
      set_segments(s);
      if (ph == 7) idle_gaps = 1'b0;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = 8'($urandom);
          c = 8'($urandom);
        end else begin
          r = 8'($urandom_range(0, s));
          c = 8'($urandom_range(0, s));
        end
        send_point(r, c);
      end
      wait_drained();
    end
  endtask

  initial begin
    seg_now = uvs_pkg::SEG_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_value();
    test_corners();
    test_random_points();
    $display("covered %0d grid points, %0d checked, segment counts 0, 1, 255 and random",
             points_sent, points_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
